[hw/rtl/scpq_pkg.sv]
// ---------------------------------------------------------------------------
// scpq_pkg - shared types, constants and coefficient tables
// Fixed-point first-quadrant sine/cosine: Q1.31 in, Q1.31 out, Q.56 inside.
// ---------------------------------------------------------------------------
package scpq_pkg;

   // Operation codes
   localparam logic OP_SINE   = 1'b0;
   localparam logic OP_COSINE = 1'b1;

   // Default term counts
   localparam int SINE_TERMS_DEF   = 12;
   localparam int COSINE_TERMS_DEF = 13;
   localparam int TBL_LEN          = 16;

   // Angle thresholds (Q1.31)
   localparam logic [31:0] Q31_ONE        = 32'h8000_0000;
   localparam logic [31:0] TINY_Q31       = 32'd16;
   localparam logic [31:0] BREAK_Q31      = 32'h6000_0000;
   localparam logic [31:0] QUARTER_PI_Q31 = 32'd1686629714;
   localparam logic [31:0] HALF_PI_Q31    = 32'd3373259426;

   // Accumulator constants (Q.56)
   localparam logic [63:0] ACC_LIMIT = 64'd1 << 60;
   localparam logic [63:0] ONE_Q56   = 64'd1 << 56;

   // Queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   // Coefficient set select
   typedef enum logic [1:0] {
      SEL_SIN_LOW,
      SEL_SIN_HIGH,
      SEL_COS
   } sel_type;

   // Classified work item handed from front to back
   typedef struct packed {
      logic [31:0] x;
      sel_type     sel;
      logic        cos_poly;
      logic        bypass;
      logic [31:0] byp_val;
   } work_type;

   // Published coefficients: significand and exponent, value = m * 2^(e-52)
   localparam logic signed [63:0] SIN_LOW_M [TBL_LEN] = '{
      64'sh196c572de7c31a, 64'sh10000000000000, -64'sh1d2c36ec769d57,
      -64'sh155555555538b8, -64'sh1385b3b40c93b7, 64'sh11111112b73132,
      -64'sh146e204174b4b0, -64'sh1a01966033bdcf, -64'sh1768168286a0ee,
      64'sh1726b4f90c06d9, -64'sh1f430a7432c234, -64'sh193f86b29401e7,
      64'sh0, 64'sh0, 64'sh0, 64'sh0};
   localparam int SIN_LOW_E [TBL_LEN] = '{
      -100, 0, -49, -3, -38, -7, -32, -13, -29, -19, -29, -26, 0, 0, 0, 0};

   localparam logic signed [63:0] SIN_HIGH_M [TBL_LEN] = '{
      64'sh15cffc16bf8f0d, 64'sh1769fec6552172, -64'sh15cffc16bfb024,
      -64'sh1f37fe5dbbb0ac, 64'sh1d15501c565ba2, 64'sh18f998817cce95,
      -64'sh1f05b2330a6d17, -64'sh1306fa74d36fd5, 64'sh11b503a151bb97,
      64'sh111d3cf9ddbcfe, -64'sh1bbe5019152203, -64'sh156b451b540879,
      64'sh0, 64'sh0, 64'sh0, 64'sh0};
   localparam int SIN_HIGH_E [TBL_LEN] = '{
      -1, -1, -2, -4, -6, -8, -11, -13, -16, -19, -23, -27, 0, 0, 0, 0};

   localparam logic signed [63:0] COS_M [TBL_LEN] = '{
      -64'sh12867404367335, 64'sh19f6df7cc70fe2, 64'sh10000000000000,
      -64'sh147f6c76fc0a5f, -64'sh15555555554506, -64'sh13a0513f39d1bb,
      64'sh16c16c18446575, -64'sh115c4ea47eac51, -64'sh1a01985ed83aff,
      -64'sh1180ab6cae5f4f, 64'sh12848957e7643d, -64'sh14e3868e1bc725,
      -64'sh10e306e7907829, 64'sh0, 64'sh0, 64'sh0};
   localparam int COS_E [TBL_LEN] = '{
      -73, -65, -1, -51, -5, -41, -10, -35, -16, -32, -22, -32, -29, 0, 0, 0};

   // Term count limited to the table
   function automatic int clamp_terms(input int n);
      if (n < 1) return 1;
      if (n > TBL_LEN) return TBL_LEN;
      return n;
   endfunction

   // Coefficient rounded to Q.56, ties away from zero
   function automatic logic signed [63:0] coef_q56(input logic signed [63:0] mant,
                                                   input int ex);
      logic        neg;
      logic [63:0] mag;
      int          sh;
      int          s;
      neg = mant[63];
      mag = neg ? 64'(-mant) : 64'(mant);
      sh  = ex + 4;
      if (sh >= 0) begin
         if (sh > 4) sh = 4;
         mag = mag << sh;
      end else begin
         s = -sh;
         if (s >= 62) mag = '0;
         else mag = (mag + (64'd1 << (s - 1))) >> s;
      end
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   // Q.56 coefficient of a set at an index; zero past the set's term count
   function automatic logic signed [63:0] coef_at(input sel_type sel, input int idx,
                                                  input int n_sin, input int n_cos);
      logic signed [63:0] c;
      c = '0;
      if (idx >= 0 && idx < TBL_LEN) begin
         case (sel)
            SEL_SIN_LOW:  if (idx < n_sin) c = coef_q56(SIN_LOW_M[idx], SIN_LOW_E[idx]);
            SEL_SIN_HIGH: if (idx < n_sin) c = coef_q56(SIN_HIGH_M[idx], SIN_HIGH_E[idx]);
            SEL_COS:      if (idx < n_cos) c = coef_q56(COS_M[idx], COS_E[idx]);
            default:      c = '0;
         endcase
      end
      return c;
   endfunction

endpackage

[hw/rtl/scpq_if.sv]
// ---------------------------------------------------------------------------
// scpq_if - request and response channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface scpq_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] angle;

   modport source (output valid, output op, output angle, input ready);
   modport sink   (input valid, input op, input angle, output ready);
endinterface

interface scpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

[hw/rtl/scpq_front.sv]
// ---------------------------------------------------------------------------
// scpq_front - request classifier
// Reflects upper-octant cosine angles, picks the coefficient set and flags tiny angles.
// ---------------------------------------------------------------------------
module scpq_front (
   input  logic                clock,
   input  logic                reset,
   scpq_req_if.sink            req_ch,
   output logic                push,
   input  logic                q_full,
   output scpq_pkg::work_type  work
);

   logic               fv_ff, fv_in;
   scpq_pkg::work_type work_ff, work_in;
   logic               take;
   logic [31:0]        xs;
   logic               sine_path;

   assign push         = fv_ff && !q_full;
   assign req_ch.ready = !fv_ff || push;
   assign take         = req_ch.valid && req_ch.ready;
   assign work         = work_ff;

   // Classify the incoming angle
   always_comb begin
      work_in   = '0;
      sine_path = 1'b1;
      xs        = req_ch.angle;
      if (req_ch.op == scpq_pkg::OP_COSINE) begin
         if (req_ch.angle >= scpq_pkg::QUARTER_PI_Q31) begin
            // upper octant: sin(pi/2 - x), saturated at zero
            xs = (req_ch.angle > scpq_pkg::HALF_PI_Q31) ? '0 :
                 scpq_pkg::HALF_PI_Q31 - req_ch.angle;
         end else begin
            sine_path = 1'b0;
            work_in.x        = req_ch.angle;
            work_in.sel      = scpq_pkg::SEL_COS;
            work_in.cos_poly = 1'b1;
            work_in.bypass   = req_ch.angle < scpq_pkg::TINY_Q31;
            work_in.byp_val  = scpq_pkg::Q31_ONE;
         end
      end
      if (sine_path) begin
         work_in.cos_poly = 1'b0;
         work_in.bypass   = xs < scpq_pkg::TINY_Q31;
         work_in.byp_val  = xs;
         if (xs >= scpq_pkg::BREAK_Q31) begin
            work_in.x   = xs - scpq_pkg::BREAK_Q31;
            work_in.sel = scpq_pkg::SEL_SIN_HIGH;
         end else begin
            work_in.x   = xs;
            work_in.sel = scpq_pkg::SEL_SIN_LOW;
         end
      end
   end

   // Holding register
   always_comb begin
      fv_in = fv_ff;
      if (push) fv_in = 1'b0;
      if (take) fv_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) fv_ff <= 1'b0;
      else fv_ff <= fv_in;
   end

   always_ff @(posedge clock) begin
      if (take) work_ff <= work_in;
   end

endmodule

[hw/rtl/scpq_queue.sv]
// ---------------------------------------------------------------------------
// scpq_queue - short FIFO between classifier and evaluator
// Register-based FIFO; head is read directly.
// ---------------------------------------------------------------------------
module scpq_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  scpq_pkg::work_type  wr_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output scpq_pkg::work_type  rd_data
);

   localparam int DEPTH = scpq_pkg::QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   scpq_pkg::work_type mem [DEPTH];
   logic [AW-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]      cnt_ff, cnt_in;

   assign full    = cnt_ff == CW'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign rd_data = mem[rp_ff];

   // Pointer and count update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= wr_data;
   end

endmodule

[hw/rtl/scpq_back.sv]
// ---------------------------------------------------------------------------
// scpq_back - pipelined Horner evaluator
// Two stages per Horner step: split multiply, then combine and add.
// ---------------------------------------------------------------------------
module scpq_back #(
   parameter int SINE_TERMS   = scpq_pkg::SINE_TERMS_DEF,
   parameter int COSINE_TERMS = scpq_pkg::COSINE_TERMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  scpq_pkg::work_type  q_data,
   output logic                pop,
   scpq_rsp_if.source          rsp_ch
);

   localparam int NS    = scpq_pkg::clamp_terms(SINE_TERMS);
   localparam int NC    = scpq_pkg::clamp_terms(COSINE_TERMS);
   localparam int NT    = (NS > NC) ? NS : NC;
   localparam int STEPS = NT - 1;
   localparam int LAST  = 2 * STEPS;

   logic                      en;
   logic [LAST:0]             vld_ff, vld_in;
   scpq_pkg::work_type        sb_ff [LAST+1];
   logic signed [63:0]        r_ff  [STEPS+1];
   logic signed [63:0]        r_in  [STEPS+1];
   logic [60:0]               hi_ff [STEPS+1];
   logic [63:0]               lo_ff [STEPS+1];
   logic                      ng_ff [STEPS+1];
   logic [60:0]               hi_in [STEPS+1];
   logic [63:0]               lo_in [STEPS+1];
   logic                      ng_in [STEPS+1];
   logic signed [63:0]        coef_w [STEPS+1];
   logic                      out_vld_ff, out_vld_in;
   logic [31:0]               value_ff, value_in;
   logic signed [63:0]        rf;
   logic [63:0]               uq;

   assign en           = !out_vld_ff || rsp_ch.ready;
   assign pop          = !q_empty && en;
   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.value = value_ff;

   // Per-step coefficient, chosen by set; index counts down the pipeline
   localparam logic signed [63:0] C0_LO = scpq_pkg::coef_at(scpq_pkg::SEL_SIN_LOW, NT-1, NS, NC);
   localparam logic signed [63:0] C0_HI = scpq_pkg::coef_at(scpq_pkg::SEL_SIN_HIGH, NT-1, NS, NC);
   localparam logic signed [63:0] C0_CS = scpq_pkg::coef_at(scpq_pkg::SEL_COS, NT-1, NS, NC);

   always_comb begin
      case (q_data.sel)
         scpq_pkg::SEL_SIN_LOW:  coef_w[0] = C0_LO;
         scpq_pkg::SEL_SIN_HIGH: coef_w[0] = C0_HI;
         default:                coef_w[0] = C0_CS;
      endcase
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_coef
      localparam int IDX = NT - 2 - k;
      localparam logic signed [63:0] CLO = scpq_pkg::coef_at(scpq_pkg::SEL_SIN_LOW, IDX, NS, NC);
      localparam logic signed [63:0] CHI = scpq_pkg::coef_at(scpq_pkg::SEL_SIN_HIGH, IDX, NS, NC);
      localparam logic signed [63:0] CCS = scpq_pkg::coef_at(scpq_pkg::SEL_COS, IDX, NS, NC);
      always_comb begin
         case (sb_ff[2*k+1].sel)
            scpq_pkg::SEL_SIN_LOW:  coef_w[k+1] = CLO;
            scpq_pkg::SEL_SIN_HIGH: coef_w[k+1] = CHI;
            default:                coef_w[k+1] = CCS;
         endcase
      end
   end

   // Horner datapath
   always_comb begin
      logic [63:0] mag;
      logic [63:0] p;
      logic [63:0] rnd;
      r_in[0] = coef_w[0];
      for (int k = 0; k <= STEPS; k++) begin
         hi_in[k] = '0;
         lo_in[k] = '0;
         ng_in[k] = 1'b0;
      end
      for (int k = 0; k < STEPS; k++) begin
         // multiply stage: saturated magnitude split into two products
         ng_in[k] = r_ff[k][63];
         mag = ng_in[k] ? 64'(-r_ff[k]) : 64'(r_ff[k]);
         if (mag > scpq_pkg::ACC_LIMIT) mag = scpq_pkg::ACC_LIMIT;
         hi_in[k] = 61'(sb_ff[2*k].x * mag[60:32]);
         lo_in[k] = 64'(sb_ff[2*k].x) * 64'(mag[31:0]);
         // combine stage: round, restore sign, add coefficient
         rnd = (lo_ff[k] + (64'd1 << 30)) >> 31;
         p   = {2'b00, hi_ff[k], 1'b0} + rnd;
         r_in[k+1] = (ng_ff[k] ? -$signed(p) : $signed(p)) + coef_w[k+1];
      end
   end

   // Valid shift
   always_comb begin
      vld_in[0] = pop;
      for (int i = 1; i <= LAST; i++) vld_in[i] = vld_ff[i-1];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= q_data;
         r_ff[0]  <= r_in[0];
         for (int i = 1; i <= LAST; i++) sb_ff[i] <= sb_ff[i-1];
         for (int k = 0; k < STEPS; k++) begin
            hi_ff[k]   <= hi_in[k];
            lo_ff[k]   <= lo_in[k];
            ng_ff[k]   <= ng_in[k];
            r_ff[k+1]  <= r_in[k+1];
         end
      end
   end

   // Final conversion to Q1.31
   always_comb begin
      rf = r_ff[STEPS];
      if (sb_ff[LAST].cos_poly) rf = $signed(scpq_pkg::ONE_Q56) - rf;
      uq = (64'(rf) + (64'd1 << 24)) >> 25;
      if (sb_ff[LAST].bypass) value_in = sb_ff[LAST].byp_val;
      else if (rf <= 0) value_in = '0;
      else if (uq > 64'(scpq_pkg::Q31_ONE)) value_in = scpq_pkg::Q31_ONE;
      else value_in = uq[31:0];
   end

   // Output register
   always_comb begin
      out_vld_in = out_vld_ff;
      if (en) out_vld_in = vld_ff[LAST];
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= out_vld_in;
   end

   always_ff @(posedge clock) begin
      if (en && vld_ff[LAST]) value_ff <= value_in;
   end

   // Checks
   a_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> value_ff <= scpq_pkg::Q31_ONE)
      else $error("result above 1.0");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[LAST]) |=> out_vld_ff)
      else $error("finished item lost");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> vld_ff[0])
      else $error("popped item not in pipeline");

endmodule

[hw/rtl/sin_cos_polynomial_first_quadrant_top.sv]
// ---------------------------------------------------------------------------
// sin_cos_polynomial_first_quadrant_top - first-quadrant sine/cosine
// Fixed-point Horner evaluation of sine and cosine for Q1.31 angles.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries op (0 sine, 1 cosine) and angle (Q1.31 radians, 0..pi/2).
//   rsp_ch returns one item per request: value, Q1.31, in request order.
//   A classifier register feeds a two-entry queue, which feeds a Horner
//   pipeline of two stages per step (split multiply, combine and add).
//   Throughput: one item per cycle while rsp_ch accepts results, set by
//   the fully pipelined Horner steps.
//   Reset (synchronous) empties the classifier, queue and pipeline.
//   When rsp_ch is stalled the pipeline holds; the queue and classifier
//   keep taking items until full, then req_ch.ready drops.
// ---------------------------------------------------------------------------
module sin_cos_polynomial_first_quadrant_top #(
   parameter int SINE_TERMS   = scpq_pkg::SINE_TERMS_DEF,
   parameter int COSINE_TERMS = scpq_pkg::COSINE_TERMS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   scpq_req_if.sink   req_ch,
   scpq_rsp_if.source rsp_ch
);

   logic               push, q_full, q_empty, pop;
   scpq_pkg::work_type f_work, q_data;

   // Classifier
   scpq_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .push   (push),
      .q_full (q_full),
      .work   (f_work)
   );

   // Decoupling queue
   scpq_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (f_work),
      .full    (q_full),
      .pop     (pop),
      .empty   (q_empty),
      .rd_data (q_data)
   );

   // Evaluator
   scpq_back #(
      .SINE_TERMS   (SINE_TERMS),
      .COSINE_TERMS (COSINE_TERMS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - testbench for the first-quadrant sine/cosine unit
// Drives angle items through the request channel and compares every result
// with a known value or an in-bench fixed-point Horner predictor. A directed
// table comes first, then random items under hold-off, idle and stall phases.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int N_RANDOM = 1000;
   localparam int N_SIN    = 12;
   localparam int N_COS    = 13;

   logic clock;
   logic reset;

   scpq_req_if req_ch ();
   scpq_rsp_if rsp_ch ();

   sin_cos_polynomial_first_quadrant_top u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // Directed row: operation, angle, optional known value
   typedef struct {
      logic        op;
      logic [31:0] angle;
      logic        known;
      logic [31:0] value;
   } row_type;

   logic [31:0] expected_values[$];
   int          mismatches;
   int          results_seen;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_cycles;

   // Coefficient tables rounded to Q.56, built once at start
   logic signed [63:0] sin_low_q[scpq_pkg::TBL_LEN];
   logic signed [63:0] sin_high_q[scpq_pkg::TBL_LEN];
   logic signed [63:0] cos_q[scpq_pkg::TBL_LEN];

   // Round a binary64 significand/exponent pair to Q.56, ties away from zero
   function automatic logic signed [63:0] round_coef(logic signed [63:0] m, int e);
      logic        neg;
      logic [63:0] mag;
      int          sh;
      neg = m[63];
      mag = neg ? 64'(-m) : 64'(m);
      sh  = e - 52 + 56;
      if (sh >= 0) begin
         mag = mag << ((sh > 4) ? 4 : sh);
      end else if (-sh >= 62) begin
         mag = '0;
      end else begin
         mag = (mag + (64'd1 << (-sh - 1))) >> (-sh);
      end
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

   // Q1.31 times Q.56, magnitude saturated then rounded with ties up
   function automatic logic signed [63:0] mul_step(logic [31:0] x, logic signed [63:0] r);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] p;
      neg = r[63];
      mag = neg ? 64'(-r) : 64'(r);
      if (mag > scpq_pkg::ACC_LIMIT) mag = scpq_pkg::ACC_LIMIT;
      hi = 64'(x) * (mag >> 32);
      lo = 64'(x) * {32'd0, mag[31:0]};
      p  = (hi << 1) + ((lo + (64'd1 << 30)) >> 31);
      return neg ? -$signed(p) : $signed(p);
   endfunction

   function automatic logic signed [63:0] horner_eval(logic [31:0] x,
                                                      scpq_pkg::sel_type sel);
      logic signed [63:0] acc;
      int                 n;
      n = (sel == scpq_pkg::SEL_COS) ? N_COS : N_SIN;
      case (sel)
         scpq_pkg::SEL_SIN_LOW:  acc = sin_low_q[n-1];
         scpq_pkg::SEL_SIN_HIGH: acc = sin_high_q[n-1];
         default:                acc = cos_q[n-1];
      endcase
      for (int i = n - 2; i >= 0; i--) begin
         case (sel)
            scpq_pkg::SEL_SIN_LOW:  acc = mul_step(x, acc) + sin_low_q[i];
            scpq_pkg::SEL_SIN_HIGH: acc = mul_step(x, acc) + sin_high_q[i];
            default:                acc = mul_step(x, acc) + cos_q[i];
         endcase
      end
      return acc;
   endfunction

   // Q.56 to Q1.31, ties up, clamped to [0, 1.0]
   function automatic logic [31:0] round_q31(logic signed [63:0] r);
      logic [63:0] u;
      if (r <= 0) return '0;
      u = (64'(r) + (64'd1 << 24)) >> 25;
      return (u > 64'(scpq_pkg::Q31_ONE)) ? scpq_pkg::Q31_ONE : u[31:0];
   endfunction

   function automatic logic [31:0] sine_of(logic [31:0] x);
      if (x < scpq_pkg::TINY_Q31) return x;
      if (x >= scpq_pkg::BREAK_Q31)
         return round_q31(horner_eval(x - scpq_pkg::BREAK_Q31, scpq_pkg::SEL_SIN_HIGH));
      return round_q31(horner_eval(x, scpq_pkg::SEL_SIN_LOW));
   endfunction

   function automatic logic [31:0] sine_cosine(logic op, logic [31:0] x);
      if (op == scpq_pkg::OP_SINE) return sine_of(x);
      if (x >= scpq_pkg::QUARTER_PI_Q31)
         return sine_of(x > scpq_pkg::HALF_PI_Q31 ? 32'd0 : scpq_pkg::HALF_PI_Q31 - x);
      if (x < scpq_pkg::TINY_Q31) return scpq_pkg::Q31_ONE;
      return round_q31((64'sd1 <<< 56) - horner_eval(x, scpq_pkg::SEL_COS));
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", expected_values.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Send one item; valid stays up after acceptance for back-to-back items
   task automatic send_angle(logic op, logic [31:0] angle, logic known, logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.angle <= angle;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_values.push_back(known ? value : sine_cosine(op, angle));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_values.size() != 0) @(negedge clock);
   endtask

   // Random angle: mostly in range, with edge bands and occasional beyond pi/2
   function automatic logic [31:0] random_angle();
      case ($urandom_range(9))
         0:       return $urandom_range(40);
         1:       return scpq_pkg::QUARTER_PI_Q31 + $urandom_range(64) - 32;
         2:       return scpq_pkg::BREAK_Q31 + $urandom_range(64) - 32;
         3:       return scpq_pkg::HALF_PI_Q31 - $urandom_range(64);
         4:       return $urandom;
         default: return $urandom_range(scpq_pkg::HALF_PI_Q31);
      endcase
   endfunction

   // Receiver: random stalls, long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles  <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result check
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (expected_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result value=%h", rsp_ch.value);
         end else begin
            logic [31:0] want;
            want = expected_values.pop_front();
            if (rsp_ch.value !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("value mismatch: expected %h actual %h", want, rsp_ch.value);
            end
         end
      end
   end

   // Stimulus
   initial begin
      row_type rows[$];
      int      sent;
      for (int i = 0; i < scpq_pkg::TBL_LEN; i++) begin
         sin_low_q[i]  = round_coef(scpq_pkg::SIN_LOW_M[i], scpq_pkg::SIN_LOW_E[i]);
         sin_high_q[i] = round_coef(scpq_pkg::SIN_HIGH_M[i], scpq_pkg::SIN_HIGH_E[i]);
         cos_q[i]      = round_coef(scpq_pkg::COS_M[i], scpq_pkg::COS_E[i]);
      end
      mismatches     = 0;
      results_seen   = 0;
      hold_cycles    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = scpq_pkg::OP_SINE;
      req_ch.angle   = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: tiny angles, thresholds, extremes, beyond pi/2
      rows = '{
         '{scpq_pkg::OP_SINE,   32'd0,                          1'b1, 32'd0},
         '{scpq_pkg::OP_SINE,   32'd15,                         1'b1, 32'd15},
         '{scpq_pkg::OP_SINE,   32'd16,                         1'b0, 32'd0},
         '{scpq_pkg::OP_COSINE, 32'd0,                          1'b1, scpq_pkg::Q31_ONE},
         '{scpq_pkg::OP_COSINE, 32'd15,                         1'b1, scpq_pkg::Q31_ONE},
         '{scpq_pkg::OP_COSINE, 32'd16,                         1'b0, 32'd0},
         '{scpq_pkg::OP_SINE,   scpq_pkg::BREAK_Q31 - 1,        1'b0, 32'd0},
         '{scpq_pkg::OP_SINE,   scpq_pkg::BREAK_Q31,            1'b0, 32'd0},
         '{scpq_pkg::OP_COSINE, scpq_pkg::QUARTER_PI_Q31 - 1,   1'b0, 32'd0},
         '{scpq_pkg::OP_COSINE, scpq_pkg::QUARTER_PI_Q31,       1'b0, 32'd0},
         '{scpq_pkg::OP_SINE,   scpq_pkg::HALF_PI_Q31,          1'b0, 32'd0},
         '{scpq_pkg::OP_COSINE, scpq_pkg::HALF_PI_Q31,          1'b1, 32'd0},
         '{scpq_pkg::OP_COSINE, scpq_pkg::HALF_PI_Q31 - 15,     1'b0, 32'd0},
         '{scpq_pkg::OP_COSINE, scpq_pkg::HALF_PI_Q31 + 1,      1'b1, 32'd0},
         '{scpq_pkg::OP_COSINE, 32'hFFFF_FFFF,                  1'b1, 32'd0},
         '{scpq_pkg::OP_SINE,   32'hFFFF_FFFF,                  1'b0, 32'd0},
         '{scpq_pkg::OP_SINE,   32'h8000_0000,                  1'b0, 32'd0},
         '{scpq_pkg::OP_COSINE, 32'h5555_5555,                  1'b0, 32'd0},
         '{scpq_pkg::OP_SINE,   32'h2AAA_AAAA,                  1'b0, 32'd0}
      };
      foreach (rows[i]) send_angle(rows[i].op, rows[i].angle, rows[i].known, rows[i].value);

      // Sender pauses until everything is back
      drain_results();

      // Receiver holds off while the sender keeps offering items
      hold_cycles = 80;
      for (int i = 0; i < 40; i++) send_angle(1'($urandom_range(1)), random_angle(), 1'b0, '0);
      drain_results();

      // Random phases: none, sender idle, receiver stalls, both
      sent = 0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 83 : (ph == 3) ? 35 : 0;
         recv_stall_pct = (ph == 2) ? 83 : (ph == 3) ? 35 : 0;
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            send_angle(1'($urandom_range(1)), random_angle(), 1'b0, '0);
            sent++;
         end
      end
      drain_results();
      repeat (50) @(negedge clock);

      $display("covered %0d random and %0d directed items, %0d results checked",
               sent, rows.size(), results_seen);
      $display("sine and cosine over tiny, reflected, break and out-of-range angles");
      if (mismatches == 0 && expected_values.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
